FILE: rtl/core/xic_pkg.sv
// Shared types and constants of the interval constraint projector.
package xic_pkg;

    localparam int NUM_W  = 73;   // dividend: C<<32 or |num|<<16
    localparam int DEN_W  = 62;   // divisor: dt^2 or w+alpha
    localparam int QW     = 40;   // quotient bits
    localparam int CNT_W  = 6;
    localparam int CW     = 37;   // bound violation
    localparam int LAM_W  = 40;   // Lagrange multiplier, Q24.16
    localparam int MB_W   = 41;   // second multiplier operand
    localparam int MP_W   = 56;   // one partial product
    localparam int PROD_W = 57;   // mul_shift16 result
    localparam int NV_W   = 58;   // signed numerator
    localparam int ADDR_W = 4;

    localparam logic [30:0]      ALPHA_SAT = 31'h7FFF_FFFF;
    localparam logic [30:0]      TS_RESET  = 31'd1092;
    localparam logic [CNT_W-1:0] ALPHA_QB  = CNT_W'(31);
    localparam logic [CNT_W-1:0] DELTA_QB  = CNT_W'(40);

    typedef enum logic [1:0] {
        REG_LEFT_COMP  = 2'd0,
        REG_RIGHT_COMP = 2'd1,
        REG_TIME_STEP  = 2'd2,
        REG_NONE       = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_T2,
        OP_ADIV,
        OP_ALATCH,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_NUM,
        OP_DDIV,
        OP_UPD,
        OP_APPLY,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic side;   // 0 left, 1 right
        logic msel;   // 0 alpha*|lambda|, 1 w*|applied|
        logic load;
    } t_cmd;

    typedef struct packed {
        logic w_zero;
        logic alpha_ok;
        logic cl_pos;
        logic cr_pos;
        logic div_done;
        logic div_busy;
    } t_stat;

endpackage

FILE: rtl/core/xic_if.sv
// Item channel interfaces of the interval constraint projector.
interface xic_in_if;
    logic               valid;
    logic               ready;
    logic        [30:0] mark_mobility;
    logic signed [31:0] mark_origin_x;
    logic signed [31:0] mark_offset_x;
    logic signed [31:0] mark_box_left;
    logic signed [31:0] mark_box_right;
    logic        [30:0] mark_advance_width;
    logic signed [31:0] base_origin_x;
    logic signed [31:0] base_offset_x;
    logic signed [31:0] base_box_left;
    logic signed [31:0] base_box_right;

    modport source (output valid, mark_mobility, mark_origin_x, mark_offset_x,
                    mark_box_left, mark_box_right, mark_advance_width, base_origin_x,
                    base_offset_x, base_box_left, base_box_right, input ready);
    modport sink (input valid, mark_mobility, mark_origin_x, mark_offset_x,
                  mark_box_left, mark_box_right, mark_advance_width, base_origin_x,
                  base_offset_x, base_box_left, base_box_right, output ready);
    modport data (input mark_mobility, mark_origin_x, mark_offset_x,
                  mark_box_left, mark_box_right, mark_advance_width, base_origin_x,
                  base_offset_x, base_box_left, base_box_right);
    modport flow (input valid, output ready);
endinterface

interface xic_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_offset_x;
    logic               left_corrected;
    logic               right_corrected;

    modport source (output valid, new_offset_x, left_corrected, right_corrected,
                    input ready);
    modport sink (input valid, new_offset_x, left_corrected, right_corrected,
                  output ready);
    modport fill (output new_offset_x, left_corrected, right_corrected);
    modport flow (output valid, input ready);
endinterface

FILE: rtl/core/xic_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detect.
module xic_div
    import xic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [CNT_W-1:0] i_qbits,
    output logic             o_busy,
    output logic             o_done,
    output logic             o_ovf,
    output logic [QW-1:0]    o_quot
);

    logic [NUM_W-1:0] hi;
    logic             ovf;
    logic [6:0]       sh;
    logic [DEN_W:0]   trial;
    logic             ge;

    logic             r_busy;
    logic             r_done;
    logic             r_ovf;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_num;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;

    assign hi    = i_num >> i_qbits;
    assign ovf   = hi >= {{(NUM_W-DEN_W){1'b0}}, i_den};
    assign sh    = 7'(NUM_W) - 7'(i_qbits);
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ovf <= ovf;
                r_rem <= hi[DEN_W-1:0];
                r_num <= i_num << sh;
                r_q   <= '0;
                r_cnt <= i_qbits;
                r_den <= i_den;
                if (ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                r_q   <= {r_q[QW-2:0], ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quot = r_q;

endmodule

FILE: rtl/core/xic_dp.sv
// Datapath: registers, multiplier, projection arithmetic and divider.
module xic_dp
    import xic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    xic_in_if.sink            i_item,
    xic_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata
);

    logic [30:0]              r_lc, r_rc, r_ts, r_al, r_ar, r_w;
    logic                     r_alpha_ok;
    logic [DEN_W-1:0]         r_t2;
    logic signed [31:0]       r_dx;
    logic signed [CW-1:0]     r_cl, r_cr;
    logic signed [LAM_W-1:0]  r_lam_l, r_lam_r;
    logic [MP_W-1:0]          r_plo;
    logic [PROD_W-1:0]        r_prod;
    logic signed [NV_W-1:0]   r_num;
    logic [LAM_W-1:0]         r_app_mag;
    logic                     r_app_neg;
    logic                     r_lflag, r_rflag;
    logic signed [31:0]       r_out_dx;
    logic                     r_out_l, r_out_r;

    t_reg                     wsel;
    logic signed [CW-1:0]     mx, mmin, mmax, bx, half, lim_l, lim_r;
    logic [30:0]              alpha_s, comp_s;
    logic signed [LAM_W-1:0]  lam_s;
    logic signed [CW-1:0]     c_s;
    logic signed [LAM_W:0]    lam_x;
    logic [MB_W-1:0]          lam_mag, mul_b;
    logic [30:0]              mul_a;
    logic [24:0]              mul_f;
    logic [MP_W-1:0]          mul_m;
    logic [NV_W-2:0]          num_mag;
    logic                     num_pos;
    logic                     div_start, div_busy, div_done, div_ovf;
    logic [NUM_W-1:0]         div_n;
    logic [DEN_W-1:0]         div_d;
    logic [CNT_W-1:0]         div_qb;
    logic [QW-1:0]            div_q;
    logic [MB_W-1:0]          dmag;
    logic signed [MB_W:0]     delta, sum;
    logic signed [LAM_W-1:0]  new_lam;
    logic signed [LAM_W:0]    applied;
    logic signed [PROD_W+1:0] dx_x, dx_res;
    logic signed [31:0]       dx_sat;

    // position arithmetic on the incoming item
    assign mx    = CW'(i_item.mark_origin_x) + CW'(i_item.mark_offset_x);
    assign mmin  = mx + CW'(i_item.mark_box_left);
    assign mmax  = mx + CW'(i_item.mark_box_right);
    assign bx    = CW'(i_item.base_origin_x) + CW'(i_item.base_offset_x);
    assign half  = CW'($signed({1'b0, i_item.mark_advance_width[30:1]}));
    assign lim_l = bx + CW'(i_item.base_box_left) - half;
    assign lim_r = bx + CW'(i_item.base_box_right) + half;

    assign alpha_s = i_cmd.side ? r_ar : r_al;
    assign comp_s  = i_cmd.side ? r_rc : r_lc;
    assign lam_s   = i_cmd.side ? r_lam_r : r_lam_l;
    assign c_s     = i_cmd.side ? r_cr : r_cl;
    assign lam_x   = {lam_s[LAM_W-1], lam_s};
    assign lam_mag = MB_W'(-lam_x);

    // one multiplier, low then high half of the second operand
    assign mul_a = i_cmd.msel ? r_w : alpha_s;
    assign mul_b = i_cmd.msel ? {1'b0, r_app_mag} : lam_mag;
    assign mul_f = (i_cmd.op == OP_MUL_HI) ? mul_b[MB_W-1:16] : {9'b0, mul_b[15:0]};
    assign mul_m = {25'b0, mul_a} * {31'b0, mul_f};

    assign num_mag = r_num[NV_W-1] ? (NV_W-1)'(-r_num) : r_num[NV_W-2:0];
    assign num_pos = !r_num[NV_W-1] && (r_num != '0);

    assign div_start = (i_cmd.op == OP_ADIV) || (i_cmd.op == OP_DDIV);
    assign div_n  = (i_cmd.op == OP_ADIV) ? {10'b0, comp_s, 32'b0} : {num_mag, 16'b0};
    assign div_d  = (i_cmd.op == OP_ADIV) ? r_t2
                  : {30'b0, 32'({1'b0, r_w}) + 32'({1'b0, alpha_s})};
    assign div_qb = (i_cmd.op == OP_ADIV) ? ALPHA_QB : DELTA_QB;

    xic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .i_qbits (div_qb),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_ovf   (div_ovf),
        .o_quot  (div_q)
    );

    // multiplier update and clamp
    assign dmag  = div_ovf ? {1'b1, {(MB_W-1){1'b0}}} : {1'b0, div_q};
    assign delta = num_pos ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    assign sum   = (MB_W+1)'(lam_s) + delta;
    always_comb begin
        priority if (!sum[MB_W] && (sum != '0)) begin
            new_lam = '0;
        end else if (sum[MB_W] && (sum[MB_W-1:LAM_W-1] != 2'b11)) begin
            new_lam = {1'b1, {(LAM_W-1){1'b0}}};
        end else begin
            new_lam = sum[LAM_W-1:0];
        end
    end
    assign applied = $signed({new_lam[LAM_W-1], new_lam}) - lam_x;

    // offset move with saturation
    assign dx_x   = (PROD_W+2)'(r_dx);
    assign dx_res = (r_app_neg ^ i_cmd.side) ? dx_x + $signed({2'b0, r_prod})
                                              : dx_x - $signed({2'b0, r_prod});
    always_comb begin
        priority if (dx_res > (PROD_W+2)'(32'sh7FFF_FFFF)) begin
            dx_sat = 32'sh7FFF_FFFF;
        end else if (dx_res < (PROD_W+2)'(-33'sh8000_0000)) begin
            dx_sat = -32'sh7FFF_FFFF - 32'sd1;
        end else begin
            dx_sat = dx_res[31:0];
        end
    end

    assign wsel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc       <= '0;
            r_rc       <= '0;
            r_ts       <= TS_RESET;
            r_alpha_ok <= 1'b0;
            r_lam_l    <= '0;
            r_lam_r    <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                r_alpha_ok <= 1'b0;
                unique case (wsel)
                    REG_LEFT_COMP:  r_lc <= pwdata[30:0];
                    REG_RIGHT_COMP: r_rc <= pwdata[30:0];
                    REG_TIME_STEP:  r_ts <= pwdata[30:0];
                    REG_NONE:       ;
                endcase
            end
            if (i_cmd.load) begin
                r_w     <= i_item.mark_mobility;
                r_dx    <= i_item.mark_offset_x;
                r_cl    <= lim_l - mmin;
                r_cr    <= mmax - lim_r;
                r_lflag <= 1'b0;
                r_rflag <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_T2: r_t2 <= {31'b0, r_ts} * {31'b0, r_ts};
                OP_ALATCH: begin
                    if (i_cmd.side) begin
                        r_ar       <= div_ovf ? ALPHA_SAT : div_q[30:0];
                        r_alpha_ok <= 1'b1;
                    end else begin
                        r_al <= div_ovf ? ALPHA_SAT : div_q[30:0];
                    end
                end
                OP_MUL_LO: r_plo  <= mul_m;
                OP_MUL_HI: r_prod <= {1'b0, mul_m} + PROD_W'(r_plo >> 16);
                OP_NUM:    r_num  <= NV_W'(c_s) - $signed({1'b0, r_prod});
                OP_UPD: begin
                    if (i_cmd.side) begin
                        r_lam_r <= new_lam;
                    end else begin
                        r_lam_l <= new_lam;
                    end
                    r_app_neg <= applied[LAM_W];
                    r_app_mag <= applied[LAM_W] ? LAM_W'(-applied) : applied[LAM_W-1:0];
                end
                OP_APPLY: begin
                    r_dx <= dx_sat;
                    if (i_cmd.side) begin
                        r_rflag <= 1'b1;
                    end else begin
                        r_lflag <= 1'b1;
                    end
                end
                OP_PUSH: begin
                    r_out_dx <= r_dx;
                    r_out_l  <= r_lflag;
                    r_out_r  <= r_rflag;
                end
                OP_NONE, OP_ADIV, OP_DDIV: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (wsel)
            REG_LEFT_COMP:  prdata = {1'b0, r_lc};
            REG_RIGHT_COMP: prdata = {1'b0, r_rc};
            REG_TIME_STEP:  prdata = {1'b0, r_ts};
            REG_NONE:       prdata = '0;
        endcase
    end

    assign o_stat.w_zero   = (r_w == '0);
    assign o_stat.alpha_ok = r_alpha_ok;
    assign o_stat.cl_pos   = !r_cl[CW-1] && (r_cl != '0);
    assign o_stat.cr_pos   = !r_cr[CW-1] && (r_cr != '0);
    assign o_stat.div_done = div_done;
    assign o_stat.div_busy = div_busy;

    assign o_result.new_offset_x    = r_out_dx;
    assign o_result.left_corrected  = r_out_l;
    assign o_result.right_corrected = r_out_r;

endmodule

FILE: rtl/core/xic_ctrl.sv
// Controller: sequences alpha refresh and both bound projections per item.
module xic_ctrl
    import xic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    xic_in_if.sink     i_item,
    xic_out_if.source  o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_T2, S_ADIV, S_AWAIT, S_SEL, S_MLO, S_MHI,
        S_NUM, S_DDIV, S_DWAIT, S_UPD, S_WLO, S_WHI, S_APPLY, S_OUT
    } t_state;

    t_state r_state;
    logic   r_side;
    logic   r_out_valid;
    logic   accept;
    logic   push;
    logic   side_pos;

    assign accept   = i_item.valid && (r_state == S_IDLE);
    assign push     = (r_state == S_OUT) && (!r_out_valid || o_result.ready);
    assign side_pos = r_side ? i_stat.cr_pos : i_stat.cl_pos;

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_NONE;
        o_cmd.side = r_side;
        o_cmd.load = accept;
        unique case (r_state)
            S_T2:    o_cmd.op = OP_T2;
            S_ADIV:  o_cmd.op = OP_ADIV;
            S_AWAIT: o_cmd.op = i_stat.div_done ? OP_ALATCH : OP_NONE;
            S_MLO:   o_cmd.op = OP_MUL_LO;
            S_MHI:   o_cmd.op = OP_MUL_HI;
            S_NUM:   o_cmd.op = OP_NUM;
            S_DDIV:  o_cmd.op = OP_DDIV;
            S_UPD:   o_cmd.op = OP_UPD;
            S_WLO: begin
                o_cmd.op   = OP_MUL_LO;
                o_cmd.msel = 1'b1;
            end
            S_WHI: begin
                o_cmd.op   = OP_MUL_HI;
                o_cmd.msel = 1'b1;
            end
            S_APPLY: o_cmd.op = OP_APPLY;
            S_OUT:   o_cmd.op = push ? OP_PUSH : OP_NONE;
            S_IDLE, S_CHECK, S_SEL, S_DWAIT: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CHECK;
                        r_side  <= 1'b0;
                    end
                end
                S_CHECK: begin
                    priority if (i_stat.w_zero) begin
                        r_state <= S_OUT;
                    end else if (!i_stat.alpha_ok) begin
                        r_state <= S_T2;
                    end else begin
                        r_state <= S_SEL;
                    end
                end
                S_T2:   r_state <= S_ADIV;
                S_ADIV: r_state <= S_AWAIT;
                S_AWAIT: begin
                    if (i_stat.div_done) begin
                        r_side  <= !r_side;
                        r_state <= r_side ? S_SEL : S_ADIV;
                    end
                end
                S_SEL: begin
                    priority if (side_pos) begin
                        r_state <= S_MLO;
                    end else if (!r_side) begin
                        r_side <= 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MLO:  r_state <= S_MHI;
                S_MHI:  r_state <= S_NUM;
                S_NUM:  r_state <= S_DDIV;
                S_DDIV: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: r_state <= S_WLO;
                S_WLO: r_state <= S_WHI;
                S_WHI: r_state <= S_APPLY;
                S_APPLY: begin
                    if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= S_SEL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (push) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;

endmodule

FILE: rtl/core/xpbd_interval_constraint_project.sv
// Top level of the XPBD two-sided interval constraint projector.
//
// channel    direction  handshake      payload
// i_item     in         valid/ready    mark and base geometry, mobility
// o_result   out        valid/ready    new_offset_x, left/right_corrected
// apb        in         psel/penable   compliances, time step
//
// One item at a time. An item with zero mobility goes straight to the result.
// Otherwise each projected side runs the 40-step shared divider (stopping at
// once when the step saturates). The first such item after a register write
// or reset first rebuilds both alphas with the divider.
// Reset is synchronous and clears both multipliers. A held result does not
// stop the next item being accepted; only the final push waits on o_result.
module xpbd_interval_constraint_project
    import xic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    xic_in_if.sink            i_item,
    xic_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cmd  cmd;
    t_stat stat;

    assign pready = 1'b1;

    xic_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

    xic_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_item   (i_item),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

    a_busy_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_busy |-> !i_item.ready)
        else $error("divider running while idle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("second item taken during work");

    a_push_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_PUSH |-> !o_result.valid || o_result.ready)
        else $error("result overwritten");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the two-sided interval constraint projector.
module tb_top
    import xic_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 2_500_000;
    localparam int  RAND_ITEMS   = 230;
    localparam logic [31:0]        W_MAX = 32'h7FFF_FFFF;
    localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] N_MIN = 32'sh8000_0000;

    typedef struct {
        logic        [30:0] mobility;
        logic signed [31:0] m_origin;
        logic signed [31:0] m_offset;
        logic signed [31:0] m_left;
        logic signed [31:0] m_right;
        logic        [30:0] width;
        logic signed [31:0] b_origin;
        logic signed [31:0] b_offset;
        logic signed [31:0] b_left;
        logic signed [31:0] b_right;
    } t_geom;

    typedef struct {
        logic signed [31:0] offset;
        logic               l_hit;
        logic               r_hit;
    } t_proj;

    typedef struct {
        t_geom g;
        bit    known;
        t_proj res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    xic_in_if  item_if ();
    xic_out_if res_if ();

    xpbd_interval_constraint_project dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [30:0] comp_left, comp_right, step_len;
    longint      lam_left, lam_right;

    t_proj due_offsets[$];
    int    errors;
    int    gap_pct, stall_pct, hold_left;
    int    cycles;

    function automatic logic [63:0] q16_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[79:16];
    endfunction

    function automatic longint q16_smul(logic [63:0] a, longint s);
        logic [63:0] mag;
        longint      r;
        mag = (s < 0) ? -s : s;
        r = longint'(q16_mul(a, mag));
        return (s < 0) ? -r : r;
    endfunction

    function automatic logic [63:0] alpha_of(logic [30:0] comp);
        logic [63:0]  t2;
        logic [127:0] a;
        t2 = 64'(step_len) * 64'(step_len);
        if (t2 == 0) return 64'h7FFF_FFFF;
        a = {65'b0, comp, 32'b0} / {64'b0, t2};
        return (a > 128'h7FFF_FFFF) ? 64'h7FFF_FFFF : a[63:0];
    endfunction

    function automatic longint side_move(longint viol, logic [63:0] alpha,
                                         logic [63:0] w, inout longint lam);
        logic [63:0]  denom, mag;
        logic [127:0] q;
        longint       num, delta, sum;
        denom = w + alpha;
        num   = viol + q16_smul(alpha, lam);
        mag   = (num > 0) ? num : -num;
        q     = ({64'b0, mag} << 16) / {64'b0, denom};
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        delta = (num > 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
        sum   = lam + delta;
        if (sum > 0) sum = 0;
        if (sum < -(64'sd1 <<< 39)) sum = -(64'sd1 <<< 39);
        delta = sum - lam;
        lam   = sum;
        return q16_smul(w, delta);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic t_proj project_dot(t_geom g);
        t_proj       r;
        longint      dx, mx, lo, hi, bx, half, cl, cr;
        logic [63:0] al, ar, w;
        w  = 64'(g.mobility);
        dx = longint'(g.m_offset);
        r.l_hit = 1'b0;
        r.r_hit = 1'b0;
        if (w != 0) begin
            al   = alpha_of(comp_left);
            ar   = alpha_of(comp_right);
            mx   = longint'(g.m_origin) + dx;
            lo   = mx + longint'(g.m_left);
            hi   = mx + longint'(g.m_right);
            half = longint'(g.width >> 1);
            bx   = longint'(g.b_origin) + longint'(g.b_offset);
            cl   = bx + longint'(g.b_left) - half - lo;
            cr   = hi - (bx + longint'(g.b_right) + half);
            if (cl > 0) begin
                r.l_hit = 1'b1;
                dx = clip32(dx - side_move(cl, al, w, lam_left));
            end
            if (cr > 0) begin
                r.r_hit = 1'b1;
                dx = clip32(dx + side_move(cr, ar, w, lam_right));
            end
        end
        r.offset = dx[31:0];
        return r;
    endfunction

    function automatic t_geom mk(logic [31:0] w, logic signed [31:0] mo, moff, ml, mr,
                                 logic [31:0] wd, logic signed [31:0] bo, boff, bl, br);
        t_geom g;
        g.mobility = w[30:0]; g.m_origin = mo; g.m_offset = moff; g.m_left = ml;
        g.m_right = mr;  g.width = wd[30:0]; g.b_origin = bo;   g.b_offset = boff;
        g.b_left = bl;   g.b_right = br;
        return g;
    endfunction

    function automatic int srand(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    function automatic t_geom rand_geom();
        t_geom g;
        int    kind;
        int    bo;
        kind = $urandom_range(99);
        if (kind < 10) begin
            g = mk($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            bo = srand(1 << 24);
            g = mk(($urandom_range(1) != 0) ? $urandom_range(1 << 17, 1) : $urandom,
                   bo + srand(1 << 21), srand(1 << 18),
                   -int'($urandom_range(1 << 19)), $urandom_range(1 << 19),
                   $urandom_range(1 << 20), bo, srand(1 << 18),
                   -int'($urandom_range(1 << 20)), $urandom_range(1 << 20));
            if (kind < 15) g.mobility = '0;
        end
        return g;
    endfunction

    task automatic tick();
        @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        tick();
        penable <= 1'b1;
        tick();
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LEFT_COMP:  comp_left  = val[30:0];
            REG_RIGHT_COMP: comp_right = val[30:0];
            REG_TIME_STEP:  step_len   = val[30:0];
            default: ;
        endcase
    endtask

    task automatic offer(t_geom g, bit known, t_proj res);
        t_proj p;
        while (int'($urandom_range(99)) < gap_pct) begin
            item_if.valid <= 1'b0;
            tick();
        end
        item_if.valid              <= 1'b1;
        item_if.mark_mobility      <= g.mobility;
        item_if.mark_origin_x      <= g.m_origin;
        item_if.mark_offset_x      <= g.m_offset;
        item_if.mark_box_left      <= g.m_left;
        item_if.mark_box_right     <= g.m_right;
        item_if.mark_advance_width <= g.width;
        item_if.base_origin_x      <= g.b_origin;
        item_if.base_offset_x      <= g.b_offset;
        item_if.base_box_left      <= g.b_left;
        item_if.base_box_right     <= g.b_right;
        do tick(); while (!(item_if.valid && item_if.ready));
        p = project_dot(g);
        due_offsets.push_back(known ? res : p);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (due_offsets.size() != 0) tick();
        repeat (200) tick();
    endtask

    // result channel: random stalls, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= int'($urandom_range(99)) >= stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_proj e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_offsets.size() == 0) begin
                $error("unexpected item: new_offset_x %h", res_if.new_offset_x);
                errors++;
            end else begin
                e = due_offsets.pop_front();
                if (res_if.new_offset_x !== e.offset) begin
                    $error("new_offset_x expected %h actual %h", e.offset,
                           res_if.new_offset_x);
                    errors++;
                end
                if (res_if.left_corrected !== e.l_hit) begin
                    $error("left_corrected expected %b actual %b", e.l_hit,
                           res_if.left_corrected);
                    errors++;
                end
                if (res_if.right_corrected !== e.r_hit) begin
                    $error("right_corrected expected %b actual %b", e.r_hit,
                           res_if.right_corrected);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("xpbd_interval_constraint_project regression: fail");
            $finish;
        end
    end

    initial begin
        t_row  rows[$];
        t_row  r;
        t_proj none;
        int    u;
        logic [31:0] cfg[6][3];
        int    modes[6][2];

        u = 1 << 16;
        errors = 0;  cycles = 0;  hold_left = 0;
        gap_pct = 0; stall_pct = 0;
        comp_left = '0; comp_right = '0; step_len = TS_RESET;
        lam_left = 0;   lam_right = 0;
        none = '{offset: '0, l_hit: 1'b0, r_hit: 1'b0};
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        item_if.valid <= 1'b0;
        item_if.mark_mobility <= '0;  item_if.mark_origin_x <= '0;
        item_if.mark_offset_x <= '0;  item_if.mark_box_left <= '0;
        item_if.mark_box_right <= '0; item_if.mark_advance_width <= '0;
        item_if.base_origin_x <= '0;  item_if.base_offset_x <= '0;
        item_if.base_box_left <= '0;  item_if.base_box_right <= '0;
        repeat (9) tick();
        i_rst_n <= 1'b1;

        // zero mobility echoes the offset; a box inside the limits is untouched
        r = '{mk('0, P_MAX, P_MAX, P_MAX, P_MAX, W_MAX, P_MAX, P_MAX, P_MAX, P_MAX),
              1, '{P_MAX, 1'b0, 1'b0}};
        rows.push_back(r);
        r = '{mk('0, N_MIN, N_MIN, N_MIN, N_MIN, '0, N_MIN, N_MIN, N_MIN, N_MIN),
              1, '{N_MIN, 1'b0, 1'b0}};
        rows.push_back(r);
        r = '{mk(W_MAX, 0, 0, 0, 0, '0, 0, 0, 0, 0), 1, none};
        rows.push_back(r);
        r.known = 0;
        r.g = mk(u, 0, 0, 0, u, 0, 10 * u, 0, 0, u);            rows.push_back(r);
        r.g = mk(u, 0, 0, 0, u, 0, -10 * u, 0, 0, u);           rows.push_back(r);
        r.g = mk(u, 0, 0, -5 * u, 5 * u, 0, 0, 0, 0, u);        rows.push_back(r);
        r.g = mk(1, 0, 3 * u, 0, u, 2 * u, 20 * u, 0, 0, u);    rows.push_back(r);
        r.g = mk(W_MAX, 0, 0, N_MIN, P_MAX, 0, 0, 0, 0, 0);     rows.push_back(r);
        r.g = mk(W_MAX, P_MAX, P_MAX, P_MAX, P_MAX, W_MAX, P_MAX, P_MAX, P_MAX,
                 P_MAX);                                       rows.push_back(r);
        r.g = mk(W_MAX, N_MIN, N_MIN, N_MIN, N_MIN, 0, N_MIN, N_MIN, N_MIN,
                 N_MIN);                                       rows.push_back(r);
        r.g = mk(u, P_MAX, P_MAX, 0, 0, 0, N_MIN, N_MIN, 0, 0); rows.push_back(r);
        r.g = mk(u, 0, 0, 0, u, 0, 10 * u, 0, 0, u);            rows.push_back(r);
        r.g = mk(W_MAX, 0, P_MAX - u, 0, P_MAX, 0, N_MIN, 0, 0, 0);
        rows.push_back(r);
        r.g = mk(W_MAX, 0, N_MIN + u, N_MIN, 0, 0, P_MAX, 0, 0, 0);
        rows.push_back(r);
        foreach (rows[i]) offer(rows[i].g, rows[i].known, rows[i].res);
        drain();

        cfg = '{'{32'd0, 32'd0, 32'd1092},
                '{32'd65536, 32'd6553, 32'd65536},
                '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1},
                '{32'd300, 32'd1, 32'h7FFF_FFFF},
                '{32'd1000, 32'd50000, 32'd0},
                '{$urandom, $urandom, $urandom_range(32'h7FFF_FFFF, 1)}};
        modes = '{'{0, 0}, '{46, 0}, '{0, 46}, '{13, 13}, '{0, 0}, '{46, 46}};
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_LEFT_COMP, cfg[ph][0]);
            reg_write(REG_RIGHT_COMP, cfg[ph][1]);
            reg_write(REG_TIME_STEP, cfg[ph][2]);
            if (ph == 0) reg_write(REG_NONE, $urandom);
            gap_pct   = modes[ph][0];
            stall_pct = modes[ph][1];
            if (ph == 4) hold_left = 600;
            for (int n = 0; n < RAND_ITEMS; n++) offer(rand_geom(), 0, none);
            drain();
        end

        if (errors == 0)
            $display("xpbd_interval_constraint_project regression: pass");
        else
            $display("xpbd_interval_constraint_project regression: fail");
        $finish;
    end
endmodule

FILE: xpbd_interval_constraint_project.f
rtl/core/xic_pkg.sv
rtl/core/xic_if.sv
rtl/core/xic_div.sv
rtl/core/xic_dp.sv
rtl/core/xic_ctrl.sv
rtl/core/xpbd_interval_constraint_project.sv
tb/sv/tb_top.sv
